>>> sv/mrp_pkg.sv
`timescale 1ns / 1ps

package mrp_pkg;

    localparam int RX_DEPTH    = 128;
    localparam int CHUNK_WORDS = 45;
    localparam int QUEUE_DEPTH = 4;

    localparam int RX_AW  = $clog2(RX_DEPTH);
    localparam int CNT_W  = $clog2(RX_DEPTH + 1);
    localparam int IDX_W  = $clog2(CHUNK_WORDS + 1);
    localparam int QA_W   = $clog2(QUEUE_DEPTH);
    localparam int QF_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [15:0] HOLD_THIRD_ADDR = 16'h0054;
    localparam logic [15:0] CHUNK_LEN       = 16'(CHUNK_WORDS);
    localparam logic [7:0]  SLAVE_RESET     = 8'h01;

    localparam logic [7:0] FN_HOLDING = 8'd3;
    localparam logic [7:0] FN_INPUT   = 8'd4;

    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_FRAME = 2'd2;

    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_REG  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic [2:0] PH_HOLD_A  = 3'd0;
    localparam logic [2:0] PH_HOLD_B  = 3'd1;
    localparam logic [2:0] PH_HOLD_C  = 3'd2;
    localparam logic [2:0] PH_INPUT_A = 3'd3;
    localparam logic [2:0] PH_INPUT_B = 3'd4;

    typedef enum logic [1:0] {
        CLS_BYTE,
        CLS_START,
        CLS_FRAME
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> sv/modbus_rtu_register_poller.sv
`timescale 1ns / 1ps

// Channel   Handshake              Words
// input     i_start / o_busy       i_command, i_rx_byte
// result    o_strobe (no stall)    o_kind, o_tx_byte, o_reg_bank, o_reg_index,
//                                  o_reg_value, o_last
// config    i_cfg_wr_en            i_cfg_wr_data (slave address)
//
// A received byte is taken from the queue and written to the receive buffer. A start is
// taken from the queue, then the eight request bytes go out back to back. A frame end is
// taken from the queue, then each register word passes S_RD_HI, S_RD_LO and S_WORD, as
// the receive buffer has a single read port; then the next request or the completion
// word follows. A four-word queue sits between the front and back ends, so o_busy rises
// only when it is full. Reset is synchronous and active low.

module modbus_rtu_register_poller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_rx_byte,
    output logic        o_busy,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_reg_bank,
    output logic [7:0]  o_reg_index,
    output logic [15:0] o_reg_value,
    output logic        o_last
);

    logic [7:0]     r_slave_address;
    mrp_pkg::t_head head;
    logic           pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= mrp_pkg::SLAVE_RESET;
        end else if (i_cfg_wr_en) begin
            r_slave_address <= i_cfg_wr_data;
        end
    end

    mrp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_command (i_command),
        .i_rx_byte (i_rx_byte),
        .i_pop     (pop),
        .o_busy    (o_busy),
        .o_head    (head)
    );

    mrp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_slave_address (r_slave_address),
        .o_pop           (pop),
        .o_strobe        (o_strobe),
        .o_kind          (o_kind),
        .o_tx_byte       (o_tx_byte),
        .o_reg_bank      (o_reg_bank),
        .o_reg_index     (o_reg_index),
        .o_reg_value     (o_reg_value),
        .o_last          (o_last)
    );

endmodule

>>> sv/mrp_front.sv
`timescale 1ns / 1ps

module mrp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [1:0]     i_command,
    input  logic [7:0]     i_rx_byte,
    input  logic           i_pop,
    output logic           o_busy,
    output mrp_pkg::t_head o_head
);

    mrp_pkg::t_item                 r_q [mrp_pkg::QUEUE_DEPTH];
    logic [mrp_pkg::QA_W-1:0]       r_wr_ptr;
    logic [mrp_pkg::QA_W-1:0]       r_rd_ptr;
    logic [mrp_pkg::QF_W-1:0]       r_fill;
    logic                           push;
    logic                           pop;
    logic                           known;
    mrp_pkg::t_item                 item;

    always_comb begin
        known     = 1'b1;
        item.data = i_rx_byte;
        case (i_command)
            mrp_pkg::CMD_BYTE:  item.cls = mrp_pkg::CLS_BYTE;
            mrp_pkg::CMD_START: item.cls = mrp_pkg::CLS_START;
            mrp_pkg::CMD_FRAME: item.cls = mrp_pkg::CLS_FRAME;
            default: begin
                item.cls = mrp_pkg::CLS_BYTE;
                known    = 1'b0;
            end
        endcase
    end

    assign o_busy       = (r_fill == mrp_pkg::QF_W'(mrp_pkg::QUEUE_DEPTH));
    assign push         = i_start && !o_busy && known;
    assign pop          = i_pop && (r_fill != '0);
    assign o_head.valid = (r_fill != '0);
    assign o_head.item  = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

>>> sv/mrp_back.sv
`timescale 1ns / 1ps

module mrp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mrp_pkg::t_head i_head,
    input  logic [7:0]     i_slave_address,
    output logic           o_pop,
    output logic           o_strobe,
    output logic [1:0]     o_kind,
    output logic [7:0]     o_tx_byte,
    output logic           o_reg_bank,
    output logic [7:0]     o_reg_index,
    output logic [15:0]    o_reg_value,
    output logic           o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_HI,
        S_RD_LO,
        S_WORD,
        S_REQ,
        S_DONE
    } t_state;

    t_state                      r_state,  n_state;
    logic [2:0]                  r_phase,  n_phase;
    logic [mrp_pkg::CNT_W-1:0]   r_count,  n_count;
    logic [mrp_pkg::IDX_W-1:0]   r_idx,    n_idx;
    logic [2:0]                  r_bidx,   n_bidx;
    logic [15:0]                 r_crc,    n_crc;
    logic [7:0]                  r_hi,     n_hi;
    logic                        r_strobe, n_strobe;
    logic [1:0]                  r_kind,   n_kind;
    logic [7:0]                  r_tx,     n_tx;
    logic                        r_bank,   n_bank;
    logic [7:0]                  r_index,  n_index;
    logic [15:0]                 r_value,  n_value;
    logic                        r_last,   n_last;

    logic [7:0]                  r_mem [mrp_pkg::RX_DEPTH];
    logic [7:0]                  r_rd_data;
    logic                        r_rd_ok;
    logic [mrp_pkg::CNT_W-1:0]   rd_pos;
    logic                        wr_en;
    logic [7:0]                  rd_byte;
    logic [7:0]                  fn_code;
    logic [15:0]                 start_addr;
    logic [7:0]                  base;
    logic                        bank;
    logic [7:0]                  frame_byte;

    always_comb begin
        case (r_phase)
            mrp_pkg::PH_HOLD_B: begin
                fn_code    = mrp_pkg::FN_HOLDING;
                start_addr = mrp_pkg::CHUNK_LEN;
                base       = 8'(mrp_pkg::CHUNK_WORDS);
            end
            mrp_pkg::PH_HOLD_C: begin
                fn_code    = mrp_pkg::FN_HOLDING;
                start_addr = mrp_pkg::HOLD_THIRD_ADDR;
                base       = 8'(2 * mrp_pkg::CHUNK_WORDS);
            end
            mrp_pkg::PH_INPUT_A: begin
                fn_code    = mrp_pkg::FN_INPUT;
                start_addr = 16'h0000;
                base       = 8'h00;
            end
            mrp_pkg::PH_INPUT_B: begin
                fn_code    = mrp_pkg::FN_INPUT;
                start_addr = mrp_pkg::CHUNK_LEN;
                base       = 8'(mrp_pkg::CHUNK_WORDS);
            end
            default: begin
                fn_code    = mrp_pkg::FN_HOLDING;
                start_addr = 16'h0000;
                base       = 8'h00;
            end
        endcase
        bank = (r_phase == mrp_pkg::PH_INPUT_A) || (r_phase == mrp_pkg::PH_INPUT_B);
    end

    always_comb begin
        case (r_bidx)
            3'd0:    frame_byte = i_slave_address;
            3'd1:    frame_byte = fn_code;
            3'd2:    frame_byte = start_addr[15:8];
            3'd3:    frame_byte = start_addr[7:0];
            3'd4:    frame_byte = mrp_pkg::CHUNK_LEN[15:8];
            3'd5:    frame_byte = mrp_pkg::CHUNK_LEN[7:0];
            3'd6:    frame_byte = r_crc[7:0];
            default: frame_byte = r_crc[15:8];
        endcase
    end

    assign rd_byte = r_rd_ok ? r_rd_data : 8'h00;
    assign o_pop   = (r_state == S_IDLE) && i_head.valid;
    assign wr_en   = o_pop && (i_head.item.cls == mrp_pkg::CLS_BYTE)
                     && (r_count < mrp_pkg::CNT_W'(mrp_pkg::RX_DEPTH));

    always_comb begin
        rd_pos = mrp_pkg::CNT_W'({r_idx, 1'b0}) + mrp_pkg::CNT_W'(3);
        if (r_state == S_RD_LO) begin
            rd_pos = rd_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[mrp_pkg::RX_AW-1:0]] <= i_head.item.data;
        end
        r_rd_data <= r_mem[rd_pos[mrp_pkg::RX_AW-1:0]];
        r_rd_ok   <= (rd_pos < r_count);
    end

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_count  = r_count;
        n_idx    = r_idx;
        n_bidx   = r_bidx;
        n_crc    = r_crc;
        n_hi     = r_hi;
        n_strobe = 1'b0;
        n_kind   = mrp_pkg::KIND_TX;
        n_tx     = 8'h00;
        n_bank   = 1'b0;
        n_index  = 8'h00;
        n_value  = 16'h0000;
        n_last   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    case (i_head.item.cls)
                        mrp_pkg::CLS_BYTE: begin
                            if (wr_en) begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        mrp_pkg::CLS_START: begin
                            n_phase = mrp_pkg::PH_HOLD_A;
                            n_count = '0;
                            n_bidx  = 3'd0;
                            n_crc   = mrp_pkg::CRC_INIT;
                            n_state = S_REQ;
                        end
                        mrp_pkg::CLS_FRAME: begin
                            if (r_phase <= mrp_pkg::PH_INPUT_B) begin
                                n_idx   = '0;
                                n_state = S_RD_HI;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_HI: begin
                n_state = S_RD_LO;
            end
            S_RD_LO: begin
                n_hi    = rd_byte;
                n_state = S_WORD;
            end
            S_WORD: begin
                n_strobe = 1'b1;
                n_kind   = mrp_pkg::KIND_REG;
                n_bank   = bank;
                n_index  = base + 8'(r_idx);
                n_value  = {r_hi, rd_byte};
                if (r_idx == mrp_pkg::IDX_W'(mrp_pkg::CHUNK_WORDS - 1)) begin
                    if (r_phase == mrp_pkg::PH_INPUT_B) begin
                        n_phase = mrp_pkg::PH_HOLD_A;
                        n_state = S_DONE;
                    end else begin
                        n_phase = r_phase + 1'b1;
                        n_count = '0;
                        n_bidx  = 3'd0;
                        n_crc   = mrp_pkg::CRC_INIT;
                        n_state = S_REQ;
                    end
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_RD_HI;
                end
            end
            S_REQ: begin
                n_strobe = 1'b1;
                n_tx     = frame_byte;
                n_bidx   = r_bidx + 1'b1;
                if (r_bidx < 3'd6) begin
                    n_crc = mrp_pkg::crc_byte(r_crc, frame_byte);
                end
                if (r_bidx == 3'd7) begin
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DONE: begin
                n_strobe = 1'b1;
                n_kind   = mrp_pkg::KIND_DONE;
                n_last   = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= mrp_pkg::PH_HOLD_A;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
        r_idx   <= n_idx;
        r_bidx  <= n_bidx;
        r_crc   <= n_crc;
        r_hi    <= n_hi;
        r_kind  <= n_kind;
        r_tx    <= n_tx;
        r_bank  <= n_bank;
        r_index <= n_index;
        r_value <= n_value;
        r_last  <= n_last;
    end

    assign o_strobe    = r_strobe;
    assign o_kind      = r_kind;
    assign o_tx_byte   = r_tx;
    assign o_reg_bank  = r_bank;
    assign o_reg_index = r_index;
    assign o_reg_value = r_value;
    assign o_last      = r_last;

endmodule

>>> sv/mrp_checker.sv
`timescale 1ns / 1ps

module mrp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_strobe,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_tx_byte,
    input logic        o_reg_bank,
    input logic [7:0]  o_reg_index,
    input logic [15:0] o_reg_value,
    input logic        o_last
);

    // The words of a request frame follow back to back up to the one marked last.
    a_req_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_kind == mrp_pkg::KIND_TX && !o_last)
        |=> (o_strobe && o_kind == mrp_pkg::KIND_TX))
        else $error("request frame interrupted");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_kind == mrp_pkg::KIND_DONE) |-> o_last)
        else $error("completion word not marked last");

    a_reg_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_kind == mrp_pkg::KIND_REG)
        |-> (o_tx_byte == 8'h00 && !o_last && o_reg_index < 8'd135))
        else $error("register word carries stray fields");

    a_tx_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_kind == mrp_pkg::KIND_TX)
        |-> (!o_reg_bank && o_reg_index == 8'h00 && o_reg_value == 16'h0000))
        else $error("transmit word carries stray fields");

    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result word straight after reset");

endmodule

bind modbus_rtu_register_poller mrp_checker u_mrp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_strobe    (o_strobe),
    .o_kind      (o_kind),
    .o_tx_byte   (o_tx_byte),
    .o_reg_bank  (o_reg_bank),
    .o_reg_index (o_reg_index),
    .o_reg_value (o_reg_value),
    .o_last      (o_last)
);
